// ===== src/lpmr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmr_pkg: shared types for the length-prefixed message ring
// Status codes, controller states and the command/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package lpmr_pkg;

  localparam int unsigned LEN_W    = 6;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CAP_W    = 16;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_SMALL = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_WR_HDR,
    S_WR_DATA,
    S_RD_HDR,
    S_RD_LEN,
    S_RD_DECIDE,
    S_RD_ISSUE,
    S_RD_EMIT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    latch_in;
    logic    wr_start;
    logic    hdr_wr;
    logic    data_wr;
    logic    rd_start;
    logic    hdr_rd;
    logic    hdr_cap;
    logic    msg_start;
    logic    byte_rd;
    logic    rd_commit;
    logic    resp_load;
    status_e resp_status;
    logic    resp_len_hdr;
    logic    out_load;
    logic    out_data;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic first;
    logic dropping;
    logic left_zero;
    logic len_zero;
    logic refuse;
    logic rd_empty;
    logic hdr_last;
    logic too_small;
    logic n_zero;
    logic last_byte;
    logic out_free;
  } sts_t;

endpackage

// ===== src/lpmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpmr_ctrl: sequencer of the message ring
// Walks one item at a time through check, header, byte and result steps.
// ----------------------------------------------------------------------------
module lpmr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lpmr_pkg::sts_t    sts_i,
  output lpmr_pkg::cmd_t    cmd_o
);

  lpmr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpmr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.resp_status = lpmr_pkg::ST_OK;
    in_stall_o        = 1'b1;
    case (state_q)
      lpmr_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = lpmr_pkg::S_CHECK;
        end
      end
      lpmr_pkg::S_CHECK: begin
        if (sts_i.mode) begin
          if (sts_i.rd_empty) begin
            cmd_o.resp_load   = 1'b1;
            cmd_o.resp_status = lpmr_pkg::ST_EMPTY;
            state_d           = lpmr_pkg::S_RESP;
          end else begin
            cmd_o.rd_start = 1'b1;
            state_d        = lpmr_pkg::S_RD_HDR;
          end
        end else if (sts_i.first) begin
          cmd_o.wr_start = 1'b1;
          if (sts_i.refuse) begin
            cmd_o.resp_load   = 1'b1;
            cmd_o.resp_status = lpmr_pkg::ST_FULL;
            state_d           = lpmr_pkg::S_RESP;
          end else begin
            state_d = lpmr_pkg::S_WR_HDR;
          end
        end else if (sts_i.dropping) begin
          cmd_o.resp_load   = 1'b1;
          cmd_o.resp_status = lpmr_pkg::ST_FULL;
          state_d           = lpmr_pkg::S_RESP;
        end else if (sts_i.left_zero) begin
          cmd_o.resp_load = 1'b1;
          state_d         = lpmr_pkg::S_RESP;
        end else begin
          state_d = lpmr_pkg::S_WR_DATA;
        end
      end
      lpmr_pkg::S_WR_HDR: begin
        cmd_o.hdr_wr = 1'b1;
        if (sts_i.hdr_last) begin
          if (sts_i.len_zero) begin
            cmd_o.resp_load = 1'b1;
            state_d         = lpmr_pkg::S_RESP;
          end else begin
            state_d = lpmr_pkg::S_WR_DATA;
          end
        end
      end
      lpmr_pkg::S_WR_DATA: begin
        cmd_o.data_wr   = 1'b1;
        cmd_o.resp_load = 1'b1;
        state_d         = lpmr_pkg::S_RESP;
      end
      lpmr_pkg::S_RD_HDR: begin
        cmd_o.hdr_rd  = 1'b1;
        cmd_o.hdr_cap = 1'b1;
        if (sts_i.hdr_last) begin
          state_d = lpmr_pkg::S_RD_LEN;
        end
      end
      lpmr_pkg::S_RD_LEN: begin
        cmd_o.hdr_cap = 1'b1;
        state_d       = lpmr_pkg::S_RD_DECIDE;
      end
      lpmr_pkg::S_RD_DECIDE: begin
        if (sts_i.too_small) begin
          cmd_o.resp_load    = 1'b1;
          cmd_o.resp_status  = lpmr_pkg::ST_SMALL;
          cmd_o.resp_len_hdr = 1'b1;
          state_d            = lpmr_pkg::S_RESP;
        end else if (sts_i.n_zero) begin
          cmd_o.rd_commit = 1'b1;
          cmd_o.resp_load = 1'b1;
          state_d         = lpmr_pkg::S_RESP;
        end else begin
          cmd_o.msg_start = 1'b1;
          state_d         = lpmr_pkg::S_RD_ISSUE;
        end
      end
      lpmr_pkg::S_RD_ISSUE: begin
        cmd_o.byte_rd = 1'b1;
        state_d       = lpmr_pkg::S_RD_EMIT;
      end
      lpmr_pkg::S_RD_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_data = 1'b1;
          if (sts_i.last_byte) begin
            cmd_o.rd_commit = 1'b1;
            state_d         = lpmr_pkg::S_IDLE;
          end else begin
            state_d = lpmr_pkg::S_RD_ISSUE;
          end
        end
      end
      lpmr_pkg::S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = lpmr_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lpmr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/lpmr_dp.sv =====
// ----------------------------------------------------------------------------
// lpmr_dp: datapath of the message ring
// Byte store, ring pointers, header decode and the output register.
// ----------------------------------------------------------------------------
module lpmr_dp #(
  parameter int unsigned BUF_BYTES    = 1024,
  parameter int unsigned MAX_MSG      = 32,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lpmr_pkg::cmd_t                cmd_i,
  output lpmr_pkg::sts_t                sts_o,
  input  logic                          mode_i,
  input  logic                          first_i,
  input  logic [lpmr_pkg::LEN_W-1:0]    msg_len_i,
  input  logic [lpmr_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic [lpmr_pkg::CAP_W-1:0]    reader_capacity_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [1:0]                    status_o,
  output logic [lpmr_pkg::BYTE_W-1:0]   out_byte_o,
  output logic [lpmr_pkg::LEN_W-1:0]    out_len_o,
  output logic                          last_o
);

  localparam int unsigned PTR_W  = $clog2(BUF_BYTES);
  localparam int unsigned FREE_W = PTR_W + 1;
  localparam int unsigned HC_W   = $clog2(HEADER_BYTES + 1);
  localparam int unsigned N_W    = $clog2(MAX_MSG + 1);
  localparam logic [PTR_W-1:0] PtrLast = PTR_W'(BUF_BYTES - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  // latched item
  logic                         mode_q, first_q;
  logic [lpmr_pkg::LEN_W-1:0]   len_q;
  logic [lpmr_pkg::BYTE_W-1:0]  byte_q;
  logic [lpmr_pkg::CAP_W-1:0]   cap_q;

  // ring state
  logic [PTR_W-1:0]             rd_ptr_q, cw_ptr_q, ww_ptr_q, ap_q;
  logic [lpmr_pkg::LEN_W-1:0]   left_q;
  logic                         drop_q;
  logic [HC_W-1:0]              hcnt_q;
  logic [lpmr_pkg::CAP_W-1:0]   len_lo_q;
  logic                         len_hi_q;
  logic [N_W-1:0]               n_q, rcnt_q;
  logic [lpmr_pkg::BYTE_W-1:0]  rd_data_q;
  lpmr_pkg::status_e            resp_status_q;
  logic [lpmr_pkg::LEN_W-1:0]   resp_len_q;

  // output register
  logic                         out_valid_q;
  lpmr_pkg::status_e            out_status_q;
  logic [lpmr_pkg::BYTE_W-1:0]  out_byte_q;
  logic [lpmr_pkg::LEN_W-1:0]   out_len_q;
  logic                         out_last_q;

  logic [lpmr_pkg::BYTE_W-1:0]  ring_q [BUF_BYTES];

  logic [FREE_W-1:0]            used, free_sp, need;
  logic                         refuse, hdr_last, too_small, over_max, out_free;
  logic [N_W-1:0]               n_val;
  logic [HC_W-1:0]              cap_idx;
  logic [lpmr_pkg::LEN_W-1:0]   new_left;
  logic [lpmr_pkg::BYTE_W-1:0]  wr_data;
  logic                         wr_en;
  logic [PTR_W-1:0]             ww_next;

  always_comb begin
    if (cw_ptr_q >= rd_ptr_q) begin
      used = {1'b0, cw_ptr_q} - {1'b0, rd_ptr_q};
    end else begin
      used = {1'b0, cw_ptr_q} + FREE_W'(BUF_BYTES) - {1'b0, rd_ptr_q};
    end
    free_sp = FREE_W'(BUF_BYTES) - used;
    need    = FREE_W'(len_q) + FREE_W'(HEADER_BYTES);
    refuse  = ({1'b0, len_q} > 7'(MAX_MSG)) || (need >= free_sp);
  end

  assign hdr_last  = (hcnt_q == HC_W'(HEADER_BYTES - 1));
  assign too_small = len_hi_q || (len_lo_q > cap_q);
  assign over_max  = len_hi_q || (len_lo_q > lpmr_pkg::CAP_W'(MAX_MSG));
  assign n_val     = over_max ? N_W'(MAX_MSG) : N_W'(len_lo_q);
  assign cap_idx   = hcnt_q - 1'b1;
  assign new_left  = first_q ? (len_q - 1'b1) : (left_q - 1'b1);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign wr_en     = cmd_i.hdr_wr || cmd_i.data_wr;
  assign wr_data   = cmd_i.hdr_wr ? ((hcnt_q == '0) ? lpmr_pkg::BYTE_W'(len_q) : '0) : byte_q;
  assign ww_next   = ptr_inc(ww_ptr_q);

  always_comb begin
    sts_o           = '0;
    sts_o.mode      = mode_q;
    sts_o.first     = first_q;
    sts_o.dropping  = drop_q;
    sts_o.left_zero = (left_q == '0);
    sts_o.len_zero  = (len_q == '0);
    sts_o.refuse    = refuse;
    sts_o.rd_empty  = (rd_ptr_q == cw_ptr_q);
    sts_o.hdr_last  = hdr_last;
    sts_o.too_small = too_small;
    sts_o.n_zero    = (n_val == '0);
    sts_o.last_byte = (rcnt_q == N_W'(1));
    sts_o.out_free  = out_free;
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_q[ww_ptr_q] <= wr_data;
    end
    if (cmd_i.hdr_rd || cmd_i.byte_rd) begin
      rd_data_q <= ring_q[ap_q];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      mode_q  <= mode_i;
      first_q <= first_i;
      len_q   <= msg_len_i;
      byte_q  <= data_byte_i;
      cap_q   <= reader_capacity_i;
    end
    if (cmd_i.rd_start) begin
      len_lo_q <= '0;
      len_hi_q <= 1'b0;
    end else if (cmd_i.hdr_cap && (hcnt_q != '0)) begin
      if (cap_idx == HC_W'(0)) begin
        len_lo_q[7:0] <= rd_data_q;
      end else if (cap_idx == HC_W'(1)) begin
        len_lo_q[15:8] <= rd_data_q;
      end else begin
        len_hi_q <= len_hi_q || (rd_data_q != '0);
      end
    end
    if (cmd_i.resp_load) begin
      resp_status_q <= cmd_i.resp_status;
      resp_len_q    <= cmd_i.resp_len_hdr ? len_lo_q[lpmr_pkg::LEN_W-1:0] : '0;
    end
    if (cmd_i.msg_start) begin
      n_q <= n_val;
    end
    if (cmd_i.out_load) begin
      if (cmd_i.out_data) begin
        out_status_q <= lpmr_pkg::ST_OK;
        out_byte_q   <= rd_data_q;
        out_len_q    <= lpmr_pkg::LEN_W'(n_q);
        out_last_q   <= (rcnt_q == N_W'(1));
      end else begin
        out_status_q <= resp_status_q;
        out_byte_q   <= '0;
        out_len_q    <= resp_len_q;
        out_last_q   <= 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      cw_ptr_q    <= '0;
      ww_ptr_q    <= '0;
      ap_q        <= '0;
      left_q      <= '0;
      drop_q      <= 1'b0;
      hcnt_q      <= '0;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_start) begin
        ww_ptr_q <= cw_ptr_q;
        left_q   <= '0;
        drop_q   <= refuse;
        hcnt_q   <= '0;
      end
      if (cmd_i.hdr_wr) begin
        ww_ptr_q <= ww_next;
        hcnt_q   <= hcnt_q + 1'b1;
        if (hdr_last && (len_q == '0)) begin
          cw_ptr_q <= ww_next;
        end
      end
      if (cmd_i.data_wr) begin
        ww_ptr_q <= ww_next;
        left_q   <= new_left;
        if (new_left == '0) begin
          cw_ptr_q <= ww_next;
        end
      end
      if (cmd_i.rd_start) begin
        ap_q   <= rd_ptr_q;
        hcnt_q <= '0;
      end
      if (cmd_i.hdr_rd) begin
        ap_q   <= ptr_inc(ap_q);
        hcnt_q <= hcnt_q + 1'b1;
      end
      if (cmd_i.byte_rd) begin
        ap_q <= ptr_inc(ap_q);
      end
      if (cmd_i.msg_start) begin
        rcnt_q <= n_val;
      end else if (cmd_i.out_load && cmd_i.out_data) begin
        rcnt_q <= rcnt_q - 1'b1;
      end
      if (cmd_i.rd_commit) begin
        rd_ptr_q <= ap_q;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign out_byte_o  = out_byte_q;
  assign out_len_o   = out_len_q;
  assign last_o      = out_last_q;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a pending result");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_ptr_q <= PtrLast) && (cw_ptr_q <= PtrLast) && (ww_ptr_q <= PtrLast))
    else $error("ring pointer beyond buffer");

  a_byte_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.data_wr && !first_q) |-> (left_q != '0) && !drop_q)
    else $error("byte stored with no open message");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && cmd_i.out_data) |-> (rcnt_q != '0))
    else $error("byte emitted past message end");
`endif

endmodule

// ===== src/length_prefixed_message_ring.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_message_ring: variable-length message ring
// A byte ring holding messages as a little-endian length header followed by
// the message bytes. Writes arrive one byte per item; a read item returns a
// whole message as one result per byte, or one empty, too-small or zero-length (OK) status.
// ----------------------------------------------------------------------------
//
//   channel | handshake                | fields
//   --------+--------------------------+-------------------------------------------------
//   in      | in_valid_i, in_stall_o   | mode, first, msg_len, data_byte, reader_capacity
//   out     | out_valid_o, out_stall_i | status, out_byte, out_len, last
//
// One item at a time; the next is taken once the last result of the current
// one sits in the output register. Steps per item: a first write walks check,
// the header bytes, its data byte and result, or skips the data byte at zero length;
// a later byte walks check, data byte and result; a refused, dropped or stray write and an
// empty read go from check to result; a read walks the header bytes and decode, then issue and emit per byte.
// Reset clears pointers, counters and output valid, not the store; a stalled output
// holds its result and holds the controller before the next load.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring #(
  parameter int unsigned BUF_BYTES    = 1024,
  parameter int unsigned MAX_MSG      = 32,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic                          first_i,
  input  logic [lpmr_pkg::LEN_W-1:0]    msg_len_i,
  input  logic [lpmr_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic [lpmr_pkg::CAP_W-1:0]    reader_capacity_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [lpmr_pkg::BYTE_W-1:0]   out_byte_o,
  output logic [lpmr_pkg::LEN_W-1:0]    out_len_o,
  output logic                          last_o
);

  lpmr_pkg::cmd_t cmd;
  lpmr_pkg::sts_t sts;

  // Sequencer: decides each step of the item from datapath status.
  lpmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: ring store, pointers, header decode and output register.
  lpmr_dp #(
    .BUF_BYTES    (BUF_BYTES),
    .MAX_MSG      (MAX_MSG),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .mode_i            (mode_i),
    .first_i           (first_i),
    .msg_len_i         (msg_len_i),
    .data_byte_i       (data_byte_i),
    .reader_capacity_i (reader_capacity_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .out_byte_o        (out_byte_o),
    .out_len_o         (out_len_o),
    .last_o            (last_o)
  );

endmodule
